// ===== design/wss_pkg.sv =====
package wss_pkg;

  localparam int FS_BITS = 14;
  localparam int MV_BITS = 15;
  localparam logic [FS_BITS-1:0] FS_RESET = 14'd5000;

  typedef enum logic [0:0] {
    CFG_AVG_MODE   = 1'b0,
    CFG_FULL_SCALE = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_BUSY,
    ST_PUBLISH
  } seq_state_t;

  typedef enum logic [1:0] {
    OP_MAX,
    OP_MIN,
    OP_AVG,
    OP_P2P
  } op_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_RND,
    U_DIV
  } unit_state_t;

endpackage

// ===== design/windowed_sample_statistics_core.sv =====
// Windowed min/max/mean/peak-to-peak of centered ADC samples (2*code - (2^ADC_BITS-1)).
// Samples without tlast are folded into the running max, min, sum and count, one transaction
// per clock while in_tready is high. The tlast sample is folded in too, then four results
// (max, min, average, peak-to-peak) are scaled to millivolts by one shared shift-add
// multiply / restoring divide unit, one bit per cycle and one result after another; a window
// end holds in_tready low until all four are done, plus any wait for a previous result
// still held in the output register. Once the count reaches 2^COUNT_BITS-1, further samples
// are dropped and count_overflow is reported. Registers: index 0 average_mode (0 mean,
// 1 midrange), index 1 full_scale_mv.
module windowed_sample_statistics_core #(
  parameter int ADC_BITS   = 10,
  parameter int COUNT_BITS = 20
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  // in_tdata: adc_sample [ADC_BITS-1:0]
  input  logic                                              in_tvalid,
  output logic                                              in_tready,
  input  logic [((ADC_BITS+7)/8)*8-1:0]                     in_tdata,
  input  logic                                              in_tlast,
  // out_tdata: max_mv, min_mv, average_mv, peak_to_peak_mv (15 bits each), sample_total
  output logic                                              out_tvalid,
  input  logic                                              out_tready,
  output logic [((4*wss_pkg::MV_BITS+COUNT_BITS+7)/8)*8-1:0] out_tdata,
  // out_tuser: count_overflow
  output logic                                              out_tuser,
  input  logic                                              cfg_we,
  input  logic [0:0]                                        cfg_addr,
  input  logic [wss_pkg::FS_BITS-1:0]                       cfg_wdata
);
  import wss_pkg::*;

  localparam int OUT_W = ((4*MV_BITS + COUNT_BITS + 7) / 8) * 8;
  localparam int DW    = ADC_BITS + COUNT_BITS;
  localparam int SW    = DW + 1;
  localparam logic signed [ADC_BITS:0] C_POS = {1'b0, {ADC_BITS{1'b1}}};
  localparam logic signed [ADC_BITS:0] C_NEG = -C_POS;

  // configuration
  logic                   avg_mode_r;
  logic [FS_BITS-1:0]     fs_r;

  // window state
  logic signed [ADC_BITS:0] run_max_r, run_max_nxt;
  logic signed [ADC_BITS:0] run_min_r, run_min_nxt;
  logic signed [SW-1:0]     run_sum_r, run_sum_nxt;
  logic [COUNT_BITS-1:0]    run_cnt_r, run_cnt_nxt;
  logic                     ovf_r, ovf_nxt;

  // sequencer
  seq_state_t             state_r, state_nxt;
  op_t                    op_r, op_nxt;
  logic [MV_BITS-1:0]     res_max_r, res_max_nxt;
  logic [MV_BITS-1:0]     res_min_r, res_min_nxt;
  logic [MV_BITS-1:0]     res_avg_r, res_avg_nxt;
  logic [MV_BITS-1:0]     res_p2p_r, res_p2p_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_data_r, out_data_nxt;
  logic                   out_user_r, out_user_nxt;

  logic                   in_acc;
  logic [ADC_BITS-1:0]    code;
  logic signed [ADC_BITS:0] c_in;
  logic signed [SW-1:0]   max_ext, min_ext;
  logic signed [SW-1:0]   unit_num;
  logic [DW-1:0]          unit_den;
  logic                   unit_start;
  logic                   unit_done;
  logic [MV_BITS-1:0]     unit_res;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign code      = in_tdata[ADC_BITS-1:0];
  assign c_in      = signed'({~code[ADC_BITS-1], code[ADC_BITS-2:0], 1'b1});
  assign max_ext   = SW'(run_max_r);
  assign min_ext   = SW'(run_min_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_mode_r <= 1'b0;
      fs_r       <= FS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_AVG_MODE:   avg_mode_r <= cfg_wdata[0];
        CFG_FULL_SCALE: fs_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_max_r   <= C_NEG;
      run_min_r   <= C_POS;
      run_sum_r   <= '0;
      run_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      state_r     <= ST_IDLE;
      op_r        <= OP_MAX;
      out_valid_r <= 1'b0;
    end else begin
      run_max_r   <= run_max_nxt;
      run_min_r   <= run_min_nxt;
      run_sum_r   <= run_sum_nxt;
      run_cnt_r   <= run_cnt_nxt;
      ovf_r       <= ovf_nxt;
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_max_r  <= res_max_nxt;
    res_min_r  <= res_min_nxt;
    res_avg_r  <= res_avg_nxt;
    res_p2p_r  <= res_p2p_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // operand select for the shared unit
  always_comb begin
    unique case (op_r)
      OP_MAX: begin
        unit_num = max_ext;
        unit_den = DW'({ADC_BITS{1'b1}});
      end
      OP_MIN: begin
        unit_num = min_ext;
        unit_den = DW'({ADC_BITS{1'b1}});
      end
      OP_AVG: begin
        if (avg_mode_r) begin
          unit_num = max_ext + min_ext;
          unit_den = DW'({{ADC_BITS{1'b1}}, 1'b0});
        end else begin
          // count * (2^ADC_BITS - 1); zero count gives zero divisor -> zero result
          unit_num = run_sum_r;
          unit_den = {run_cnt_r, {ADC_BITS{1'b0}}} - DW'(run_cnt_r);
        end
      end
      OP_P2P: begin
        unit_num = max_ext - min_ext;
        unit_den = DW'({ADC_BITS{1'b1}});
      end
      default: begin
        unit_num = '0;
        unit_den = '0;
      end
    endcase
  end

  always_comb begin
    run_max_nxt   = run_max_r;
    run_min_nxt   = run_min_r;
    run_sum_nxt   = run_sum_r;
    run_cnt_nxt   = run_cnt_r;
    ovf_nxt       = ovf_r;
    state_nxt     = state_r;
    op_nxt        = op_r;
    res_max_nxt   = res_max_r;
    res_min_nxt   = res_min_r;
    res_avg_nxt   = res_avg_r;
    res_p2p_nxt   = res_p2p_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    unit_start    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (&run_cnt_r) begin
            ovf_nxt = 1'b1;
          end else begin
            if (c_in > run_max_r) run_max_nxt = c_in;
            if (c_in < run_min_r) run_min_nxt = c_in;
            run_sum_nxt = run_sum_r + SW'(c_in);
            run_cnt_nxt = run_cnt_r + 1'b1;
          end
          if (in_tlast) begin
            op_nxt    = OP_MAX;
            state_nxt = ST_LAUNCH;
          end
        end
      end
      ST_LAUNCH: begin
        unit_start = 1'b1;
        state_nxt  = ST_BUSY;
      end
      ST_BUSY: begin
        if (unit_done) begin
          unique case (op_r)
            OP_MAX: begin
              res_max_nxt = unit_res;
              op_nxt      = OP_MIN;
              state_nxt   = ST_LAUNCH;
            end
            OP_MIN: begin
              res_min_nxt = unit_res;
              op_nxt      = OP_AVG;
              state_nxt   = ST_LAUNCH;
            end
            OP_AVG: begin
              res_avg_nxt = unit_res;
              op_nxt      = OP_P2P;
              state_nxt   = ST_LAUNCH;
            end
            OP_P2P: begin
              res_p2p_nxt = unit_res;
              state_nxt   = ST_PUBLISH;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PUBLISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({run_cnt_r, res_p2p_r, res_avg_r, res_min_r, res_max_r});
          out_user_nxt  = ovf_r;
          run_max_nxt   = C_NEG;
          run_min_nxt   = C_POS;
          run_sum_nxt   = '0;
          run_cnt_nxt   = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  wss_muldiv #(
    .NUM_W (SW),
    .DEN_W (DW)
  ) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (unit_start),
    .num    (unit_num),
    .fs     (fs_r),
    .den    (unit_den),
    .done   (unit_done),
    .result (unit_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== design/wss_muldiv.sv =====
// Shared iterative unit: result = round(num * fs / den), ties away from zero.
// Shift-add multiply (one fs bit per cycle), one rounding add, then restoring
// division (one quotient bit per cycle). den == 0 gives zero.
module wss_muldiv #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 30
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [NUM_W-1:0]        num,
  input  logic [wss_pkg::FS_BITS-1:0]    fs,
  input  logic [DEN_W-1:0]               den,
  output logic                           done,
  output logic [wss_pkg::MV_BITS-1:0]    result
);
  import wss_pkg::*;

  localparam int MAG_W = NUM_W - 1;
  localparam int QW    = MAG_W + FS_BITS + 1;
  localparam int CW    = $clog2(QW);

  unit_state_t          state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [QW-1:0]        acc_r, acc_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [MAG_W-1:0]     mag_r, mag_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [FS_BITS-1:0]   fs_r, fs_nxt;
  logic                 neg_r, neg_nxt;
  logic                 done_r, done_nxt;
  logic [MV_BITS-1:0]   res_r, res_nxt;

  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       trial_sub;
  logic                 fits;
  logic [QW-1:0]        quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    mag_r <= mag_nxt;
    den_r <= den_nxt;
    fs_r  <= fs_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    mag_nxt   = mag_r;
    den_nxt   = den_r;
    fs_nxt    = fs_r;
    neg_nxt   = neg_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;

    trial     = {rem_r, acc_r[QW-1]};
    trial_sub = trial - {1'b0, den_r};
    fits      = (trial >= {1'b0, den_r});
    quo       = {acc_r[QW-2:0], fits};

    unique case (state_r)
      U_IDLE: begin
        if (start) begin
          neg_nxt   = num[NUM_W-1];
          mag_nxt   = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
          den_nxt   = den;
          fs_nxt    = fs;
          acc_nxt   = '0;
          rem_nxt   = '0;
          cnt_nxt   = CW'(FS_BITS - 1);
          state_nxt = U_MUL;
        end
      end
      U_MUL: begin
        // MSB-first shift-add over the full-scale bits
        acc_nxt = {acc_r[QW-2:0], 1'b0} + (fs_r[FS_BITS-1] ? QW'(mag_r) : {QW{1'b0}});
        fs_nxt  = {fs_r[FS_BITS-2:0], 1'b0};
        if (cnt_r == '0) begin
          state_nxt = U_RND;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      U_RND: begin
        acc_nxt   = acc_r + QW'(den_r >> 1);
        cnt_nxt   = CW'(QW - 1);
        state_nxt = U_DIV;
      end
      U_DIV: begin
        rem_nxt = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        acc_nxt = quo;
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = U_IDLE;
          if (den_r == '0) begin
            res_nxt = '0;
          end else if (neg_r) begin
            res_nxt = -quo[MV_BITS-1:0];
          end else begin
            res_nxt = quo[MV_BITS-1:0];
          end
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: state_nxt = U_IDLE;
    endcase
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== design/wss_checker.sv =====
module wss_checker #(
  parameter int ADC_BITS   = 10,
  parameter int COUNT_BITS = 20
) (
  input logic                                              clk,
  input logic                                              rst_n,
  input logic                                              in_tvalid,
  input logic                                              in_tready,
  input logic                                              in_tlast,
  input logic                                              out_tvalid,
  input logic                                              out_tready,
  input logic [((4*wss_pkg::MV_BITS+COUNT_BITS+7)/8)*8-1:0] out_tdata,
  input logic                                              out_tuser
);
  import wss_pkg::*;

  // window end starts the scaling sequence, so the input side stalls
  a_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("in_tready still high after window end");

  // ordinary samples never stall the input
  a_sample_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> in_tready)
    else $error("in_tready dropped after a non-final sample");

  // a new result only appears at the end of a stalled computation
  a_result_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without a preceding computation");

  // every reported window holds at least one sample
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4*MV_BITS +: COUNT_BITS] != '0))
    else $error("result with zero sample_total");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output transaction changed while stalled");

endmodule

bind windowed_sample_statistics_core wss_checker #(
  .ADC_BITS   (ADC_BITS),
  .COUNT_BITS (COUNT_BITS)
) u_wss_checker (.*);
